FILE: rtl/sfp_pkg.sv
// Shared types and constants for the sentence frame parser.
// Holds character codes, phase and status codes, register indexes and the
// structs that pass between the parser's modules. No dependencies.
`default_nettype none

package sfp_pkg;

   // Framing characters.
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;

   // Reset values of the limit registers.
   localparam logic [3:0] TYPE_LIMIT_RESET    = 4'd6;
   localparam logic [7:0] PAYLOAD_LIMIT_RESET = 8'd100;

   // Parser phases.
   localparam logic [1:0] PH_HUNT    = 2'd0;
   localparam logic [1:0] PH_TYPE    = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;

   // Result status codes.
   localparam logic [1:0] ST_NONE  = 2'd0;
   localparam logic [1:0] ST_DONE  = 2'd1;
   localparam logic [1:0] ST_ERROR = 2'd2;

   // Register indexes (word address bit 2).
   localparam logic REG_TYPE_LIMIT    = 1'b0;
   localparam logic REG_PAYLOAD_LIMIT = 1'b1;

   typedef struct packed {
      logic [3:0] type_limit;
      logic [7:0] payload_limit;
   } sfp_limits_type;

   typedef struct packed {
      logic [1:0] status;
      logic       store_type;
      logic       store_payload;
      logic [6:0] store_index;
      logic [7:0] store_char;
      logic [3:0] type_length;
      logic [7:0] payload_length;
   } sfp_result_type;

endpackage

`default_nettype wire

FILE: rtl/sfp_csr.sv
// Configuration registers of the sentence frame parser on an APB-style port.
// Depends on sfp_pkg for register indexes, reset values and the limits struct.
`default_nettype none

module sfp_csr (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [2:0]            paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   output sfp_pkg::sfp_limits_type    limits
);
   import sfp_pkg::*;

   logic [3:0] type_limit_ff, type_limit_in;
   logic [7:0] payload_limit_ff, payload_limit_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   // The low two address bits are byte offsets within the word.
   always_comb begin
      type_limit_in    = type_limit_ff;
      payload_limit_in = payload_limit_ff;
      if (wr_en) begin
         unique case (paddr[2])
            REG_TYPE_LIMIT:    type_limit_in    = pwdata[3:0];
            REG_PAYLOAD_LIMIT: payload_limit_in = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         type_limit_ff    <= TYPE_LIMIT_RESET;
         payload_limit_ff <= PAYLOAD_LIMIT_RESET;
      end else begin
         type_limit_ff    <= type_limit_in;
         payload_limit_ff <= payload_limit_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_TYPE_LIMIT:    prdata = {28'd0, type_limit_ff};
         REG_PAYLOAD_LIMIT: prdata = {24'd0, payload_limit_ff};
         default:           prdata = 32'd0;
      endcase
   end

   assign limits.type_limit    = type_limit_ff;
   assign limits.payload_limit = payload_limit_ff;

endmodule

`default_nettype wire

FILE: rtl/sfp_core.sv
// Phase and count state of the sentence frame parser and the per-byte step.
// Depends on sfp_pkg for codes, characters and the limits and result structs.
`default_nettype none

module sfp_core #(
   parameter int TYPE_DEPTH    = 8,
   parameter int PAYLOAD_DEPTH = 128
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step_en,
   input  wire logic [7:0]            rx_byte,
   input  wire sfp_pkg::sfp_limits_type limits,
   output sfp_pkg::sfp_result_type    result
);
   import sfp_pkg::*;

   logic [1:0] phase_ff, phase_in;
   logic [3:0] type_count_ff, type_count_in;
   logic [7:0] payload_count_ff, payload_count_in;
   logic [4:0] type_lim;
   logic [8:0] payload_lim;

   // A limit above the buffer depth acts as the depth.
   assign type_lim = (32'(limits.type_limit) > TYPE_DEPTH) ?
                     5'(TYPE_DEPTH) : {1'b0, limits.type_limit};
   assign payload_lim = (32'(limits.payload_limit) > PAYLOAD_DEPTH) ?
                        9'(PAYLOAD_DEPTH) : {1'b0, limits.payload_limit};

   always_comb begin
      phase_in         = phase_ff;
      type_count_in    = type_count_ff;
      payload_count_in = payload_count_ff;
      result           = '0;
      result.status    = ST_NONE;
      unique case (phase_ff)
         PH_TYPE: begin
            // Comma wins over the limit, and the limit wins over the star.
            if (rx_byte == CHAR_COMMA) begin
               phase_in         = PH_PAYLOAD;
               payload_count_in = 8'd0;
            end else if ({1'b0, type_count_ff} >= type_lim) begin
               phase_in      = PH_HUNT;
               type_count_in = 4'd0;
               result.status = ST_ERROR;
            end else if (rx_byte == CHAR_STAR) begin
               phase_in           = PH_HUNT;
               result.status      = ST_DONE;
               result.type_length = type_count_ff;
            end else begin
               result.store_type  = 1'b1;
               result.store_index = {3'd0, type_count_ff};
               result.store_char  = rx_byte;
               type_count_in      = 4'(type_count_ff + 4'd1);
            end
         end
         PH_PAYLOAD: begin
            if (rx_byte == CHAR_STAR) begin
               phase_in              = PH_HUNT;
               result.status         = ST_DONE;
               result.type_length    = type_count_ff;
               result.payload_length = payload_count_ff;
            end else if ({1'b0, payload_count_ff} >= payload_lim) begin
               phase_in         = PH_HUNT;
               payload_count_in = 8'd0;
               result.status    = ST_ERROR;
            end else begin
               result.store_payload = 1'b1;
               result.store_index   = payload_count_ff[6:0];
               result.store_char    = rx_byte;
               payload_count_in     = 8'(payload_count_ff + 8'd1);
            end
         end
         default: begin
            // Hunting, and the unused code behaves the same way.
            phase_in = PH_HUNT;
            if (rx_byte == CHAR_DOLLAR) begin
               phase_in      = PH_TYPE;
               type_count_in = 4'd0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HUNT;
         type_count_ff    <= 4'd0;
         payload_count_ff <= 8'd0;
      end else if (step_en) begin
         phase_ff         <= phase_in;
         type_count_ff    <= type_count_in;
         payload_count_ff <= payload_count_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/sentence_frame_parser.sv
// Sentence frame parser: top level with input register, step and result register.
// Depends on sfp_pkg, sfp_csr and sfp_core.
`default_nettype none

// The parser frames sentences of the form $TYPE,PAYLOAD* or $TYPE* from a
// stream of received bytes, one byte per item on the req_ channel, and returns
// exactly one result item on the rsp_ channel for every byte. A result either
// reports a character to store (into the type or the payload buffer, with its
// index), a completed message with its type and payload lengths, a parse error
// when a limit is exceeded, or nothing at all. The block sustains one item per
// clock cycle while the result side is not stalled: an accepted byte is held
// in the input register, the phase and count update runs in a single pass of
// logic, and the result is held in the result register. Both registers form a
// two-deep pipeline, so the input register can still take one byte while a
// result waits. The limits are set through the csr_ port and should only be
// written while the parser is idle; a limit above the buffer depth acts as that
// depth.

module sentence_frame_parser #(
   parameter int TYPE_DEPTH    = 8,
   parameter int PAYLOAD_DEPTH = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] rx_byte
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,    // [6:0] store_index, [14:7] store_char,
                                          // [18:15] type_length,
                                          // [26:19] payload_length, rest zero
   output logic [3:0]       rsp_tuser,    // [1:0] status, [2] store_type,
                                          // [3] store_payload
   // Configuration port.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import sfp_pkg::*;

   sfp_limits_type limits;
   sfp_result_type step_result;

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff, in_byte_in;
   logic           rsp_valid_ff, rsp_valid_in;
   sfp_result_type rsp_ff, rsp_in;
   logic           out_ready;
   logic           step_en;

   sfp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .limits  (limits)
   );

   // The result register can take a new result when it is empty or being
   // drained this cycle; the input register in turn can refill as it moves on.
   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || out_ready;
   assign step_en    = in_valid_ff && out_ready;

   sfp_core #(
      .TYPE_DEPTH    (TYPE_DEPTH),
      .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .rx_byte (in_byte_ff),
      .limits  (limits),
      .result  (step_result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
      end
      if (out_ready) begin
         rsp_valid_in = in_valid_ff;
         rsp_in       = step_result;
      end
   end

   // Control state is cleared by reset; the payload registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff.payload_length, rsp_ff.type_length,
                        rsp_ff.store_char, rsp_ff.store_index};
   assign rsp_tuser  = {rsp_ff.store_payload, rsp_ff.store_type, rsp_ff.status};

`ifndef SYNTHESIS
   // A result never stores into both buffers at once.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[2] && rsp_tuser[3]))
      else $error("result stores into both buffers");

   // A completed message or an error carries no store write.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1:0] != ST_NONE) |-> !(rsp_tuser[2] || rsp_tuser[3]))
      else $error("status result also carries a store write");

   // The status field only ever holds a defined code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[1:0] == ST_NONE || rsp_tuser[1:0] == ST_DONE ||
                      rsp_tuser[1:0] == ST_ERROR))
      else $error("undefined status code");

   // With both pipeline registers full and the result stalled, no byte enters.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while pipeline is full");

   // A stepped byte always reaches the result register when it is stepped.
   assert property (@(posedge clock) disable iff (reset)
      step_en |=> rsp_valid_ff)
      else $error("step result lost");
`endif

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the sentence frame parser (sentence_frame_parser).
// Drives bytes on req_, checks every rsp_ item against an in-bench frame predictor
// and sweeps the limit registers over csr_. Depends on sfp_pkg and the parser RTL.
`timescale 1ns / 100ps

module testbench;
   import sfp_pkg::*;

   localparam int TYPE_DEPTH    = 8;
   localparam int PAYLOAD_DEPTH = 128;

   // Clock of 2 ns period and a synchronous reset held at the start.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   // Every input of the parser starts at a known value.
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'h00;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;             // [6:0] store_index, [14:7] store_char,
                                       // [18:15] type_length, [26:19] payload_length
   logic [3:0]  rsp_tuser;             // [1:0] status, [2] store_type, [3] store_payload
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = 3'd0;
   logic [31:0] csr_pwdata  = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sentence_frame_parser #(
      .TYPE_DEPTH    (TYPE_DEPTH),
      .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Bytes waiting to be sent, and the results that the predictor has worked out
   // for bytes already accepted, oldest first.
   logic [7:0]     tx_bytes[$];
   sfp_result_type due_results[$];
   int             error_count = 0;

   // Handshakes seen at the last rising edge; the falling-edge processes read them.
   bit req_fired = 1'b0;
   bit rsp_fired = 1'b0;
   // Idle state of both sides. A quiet side does not idle at all for a stretch.
   int req_gap    = 0;
   int rsp_stall  = 0;
   bit req_quiet  = 1'b0;
   bit rsp_quiet  = 1'b0;

   // Predictor state: the frame phase, both counts and the two limit registers.
   logic [1:0] frame_phase;
   logic [3:0] type_count;
   logic [7:0] body_count;
   logic [3:0] lim_type;
   logic [7:0] lim_body;

   // Works out the result of one received byte and advances the predictor state.
   // Within the type the comma is tested before the limit, and the limit before
   // the star, so a type that has reached its limit cannot be closed by a star.
   // A payload that has reached its limit can still be closed by a star.
   function automatic sfp_result_type frame_step(input logic [7:0] c);
      sfp_result_type r;
      int tlim;
      int plim;
      r = '0;
      tlim = (lim_type > TYPE_DEPTH) ? TYPE_DEPTH : lim_type;
      plim = (lim_body > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : lim_body;
      case (frame_phase)
         PH_TYPE: begin
            if (c == CHAR_COMMA) begin
               frame_phase = PH_PAYLOAD;
               body_count  = 8'd0;
            end else if (type_count >= tlim) begin
               frame_phase = PH_HUNT;
               type_count  = 4'd0;
               r.status    = ST_ERROR;
            end else if (c == CHAR_STAR) begin
               frame_phase   = PH_HUNT;
               r.status      = ST_DONE;
               r.type_length = type_count;
            end else begin
               r.store_type  = 1'b1;
               r.store_index = {3'b000, type_count};
               r.store_char  = c;
               type_count    = type_count + 4'd1;
            end
         end
         PH_PAYLOAD: begin
            if (c == CHAR_STAR) begin
               frame_phase      = PH_HUNT;
               r.status         = ST_DONE;
               r.type_length    = type_count;
               r.payload_length = body_count;
            end else if (body_count >= plim) begin
               frame_phase = PH_HUNT;
               body_count  = 8'd0;
               r.status    = ST_ERROR;
            end else begin
               r.store_payload = 1'b1;
               r.store_index   = body_count[6:0];
               r.store_char    = c;
               body_count      = body_count + 8'd1;
            end
         end
         default: begin
            // Hunting, and the unused phase code too: only a dollar starts a frame.
            frame_phase = PH_HUNT;
            if (c == CHAR_DOLLAR) begin
               frame_phase = PH_TYPE;
               type_count  = 4'd0;
            end
         end
      endcase
      return r;
   endfunction

   // Idle lengths: mostly none or short, now and then long.
   function automatic int pick_gap(input bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // A character for the type or the payload. Stars never appear in either, and
   // commas never in the type, so that the length of the frame stays as planned;
   // dollars are mixed in often, since a dollar inside a frame is plain data.
   function automatic logic [7:0] text_char(input bit in_type);
      logic [7:0] c;
      c = 8'($urandom);
      if ($urandom_range(0, 19) == 0)
         c = CHAR_DOLLAR;
      else if (c == CHAR_STAR || (in_type && c == CHAR_COMMA))
         c = 8'h41 + 8'($urandom_range(0, 25));
      return c;
   endfunction

   // A length up to the limit, often short and often exactly at the limit.
   function automatic int pick_len(input int lim);
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return $urandom_range(0, (lim < 6) ? lim : 6);
      if (r < 9) return lim;
      return $urandom_range(0, lim);
   endfunction

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++)
         tx_bytes.push_back(s[i]);
   endtask

   task automatic queue_sentence(input int tlen, input bit has_body, input int plen,
                                 input bit closed);
      tx_bytes.push_back(CHAR_DOLLAR);
      for (int i = 0; i < tlen; i++)
         tx_bytes.push_back(text_char(1'b1));
      if (has_body) begin
         tx_bytes.push_back(CHAR_COMMA);
         for (int i = 0; i < plen; i++)
            tx_bytes.push_back(text_char(1'b0));
      end
      if (closed)
         tx_bytes.push_back(CHAR_STAR);
   endtask

   // Random traffic for one limit setting. Most of it is well-formed sentences,
   // the rest sentences that overrun a limit or lack their star, and line noise.
   // The noise is not counted, since the parser only skips it while hunting.
   task automatic queue_traffic(input int n, input int tlim, input int plim);
      int sent;
      int mark;
      int kind;
      sent = 0;
      while (sent < n) begin
         mark = tx_bytes.size();
         kind = $urandom_range(0, 99);
         if (kind < 75) begin
            queue_sentence(pick_len(tlim), $urandom_range(0, 3) != 0, pick_len(plim), 1'b1);
            sent += tx_bytes.size() - mark;
         end else if (kind < 90) begin
            queue_sentence($urandom_range(0, tlim + 2), 1'($urandom_range(0, 1)),
                           $urandom_range(0, plim + 2), 1'($urandom_range(0, 1)));
            sent += tx_bytes.size() - mark;
         end else begin
            repeat ($urandom_range(1, 4)) tx_bytes.push_back(8'($urandom));
         end
      end
   endtask

   // Holds the stimulus back until every byte is accepted and every result has come,
   // then keeps waiting on the clock so that the parser is certainly idle.
   task automatic wait_for_idle();
      while (tx_bytes.size() != 0 || req_tvalid || due_results.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Setup cycle, then access cycle held until the write is taken.
   task automatic csr_write(input logic reg_index, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_limits(input int tl, input int pl);
      csr_write(REG_TYPE_LIMIT, 32'(tl));
      csr_write(REG_PAYLOAD_LIMIT, 32'(pl));
   endtask

   task automatic report_field(input string name, input int want, input int seen);
      error_count++;
      if (error_count <= 50)
         $display("%0t ns: %s expected %0d, got %0d", $time, name, want, seen);
   endtask

   // Sender: presents the next byte at the falling edge once the previous one has
   // been taken and its gap has run out. tvalid gets exactly one update per edge.
   always @(negedge clock) begin : sender
      logic keep_valid;
      keep_valid = req_tvalid;
      if (!reset) begin
         if (req_fired)
            keep_valid = 1'b0;
         if (!keep_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (tx_bytes.size() > 0) begin
               req_tdata  <= tx_bytes.pop_front();
               keep_valid = 1'b1;
               req_gap    = pick_gap(req_quiet);
               if ($urandom_range(0, 63) == 0) req_quiet = !req_quiet;
            end
         end
      end
      req_tvalid <= keep_valid;
   end

   // Receiver: stalls after some results and now and then at random, so stalls
   // also fall while a result is already waiting.
   always @(negedge clock) begin : receiver
      if (!reset) begin
         if (rsp_stall > 0)
            rsp_stall--;
         else if (rsp_fired || $urandom_range(0, 19) == 0)
            rsp_stall = pick_gap(rsp_quiet);
         if (rsp_fired && $urandom_range(0, 63) == 0) rsp_quiet = !rsp_quiet;
      end
      rsp_tready <= !reset && rsp_stall == 0;
   end

   // Everything is sampled at the rising edge. Register writes and accepted bytes
   // update the predictor; each accepted result is checked against the oldest
   // expectation, field by field.
   always @(posedge clock) begin : sampler
      sfp_result_type want;
      sfp_result_type seen;
      req_fired = !reset && req_tvalid && req_tready;
      rsp_fired = !reset && rsp_tvalid && rsp_tready;
      if (reset) begin
         frame_phase = PH_HUNT;
         type_count  = 4'd0;
         body_count  = 8'd0;
         lim_type    = TYPE_LIMIT_RESET;
         lim_body    = PAYLOAD_LIMIT_RESET;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_TYPE_LIMIT)
               lim_type = csr_pwdata[3:0];
            else
               lim_body = csr_pwdata[7:0];
         end
         if (req_fired)
            due_results.push_back(frame_step(req_tdata));
         if (rsp_fired) begin
            seen.status         = rsp_tuser[1:0];
            seen.store_type     = rsp_tuser[2];
            seen.store_payload  = rsp_tuser[3];
            seen.store_index    = rsp_tdata[6:0];
            seen.store_char     = rsp_tdata[14:7];
            seen.type_length    = rsp_tdata[18:15];
            seen.payload_length = rsp_tdata[26:19];
            if (due_results.size() == 0) begin
               error_count++;
               $display("%0t ns: result with nothing expected, tuser %h tdata %h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = due_results.pop_front();
               if (seen.status !== want.status)
                  report_field("status", want.status, seen.status);
               if (seen.store_type !== want.store_type)
                  report_field("store_type", want.store_type, seen.store_type);
               if (seen.store_payload !== want.store_payload)
                  report_field("store_payload", want.store_payload, seen.store_payload);
               if (seen.store_index !== want.store_index)
                  report_field("store_index", want.store_index, seen.store_index);
               if (seen.store_char !== want.store_char)
                  report_field("store_char", want.store_char, seen.store_char);
               if (seen.type_length !== want.type_length)
                  report_field("type_length", want.type_length, seen.type_length);
               if (seen.payload_length !== want.payload_length)
                  report_field("payload_length", want.payload_length, seen.payload_length);
            end
         end
      end
   end

   // Stimulus. Each limit setting is a phase of its own; between phases the sender
   // waits for every result, which also gives the pause with nothing in flight.
   initial begin : stimulus
      int tl_set[9];
      int pl_set[9];
      tl_set = '{15, 1, 8, 9, 3, 0, 4, 0, 0};
      pl_set = '{255, 1, 128, 129, 5, 0, 0, 12, 0};
      tl_set[8] = $urandom_range(1, 8);
      pl_set[8] = $urandom_range(1, 128);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, at the reset limits: bytes at both extremes while hunting, a
      // dollar and a comma inside the payload, and a type of full length closed
      // by a star, which is an error.
      tx_bytes.push_back(8'h00);
      tx_bytes.push_back(8'hFF);
      queue_text("$AB,$,*");
      queue_text("$ABCDEF*");
      wait_for_idle();

      // Directed, with both limits at zero: a star straight after the dollar is
      // an error, an empty type and payload complete, and any payload byte fails.
      set_limits(0, 0);
      queue_text("$*$,*$,x");
      wait_for_idle();

      foreach (tl_set[i]) begin
         set_limits(tl_set[i], pl_set[i]);
         queue_traffic(140,
                       (tl_set[i] > TYPE_DEPTH) ? TYPE_DEPTH : tl_set[i],
                       (pl_set[i] > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : pl_set[i]);
         wait_for_idle();
      end

      // Let the clock run on for any stray result.
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   // The slowest correct run is well under 200 us.
   initial begin : watchdog
      #1000000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule

FILE: sim.f
rtl/sfp_pkg.sv
rtl/sfp_csr.sv
rtl/sfp_core.sv
rtl/sentence_frame_parser.sv
tb/testbench.sv
